@@ src/msbs_pkg.sv @@
// Shared constants and types for the multi-signature byte scanner.
// No dependencies; used by src/multi_signature_byte_scanner.sv.
package msbs_pkg;

	// configuration register map
	localparam int CFG_IDX_W = 3;
	localparam int PAT_W     = 64;
	localparam int LEN_W     = 4;
	localparam int VALUE_W   = 32;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_PATTERN_0 = 3'd0;
	localparam cfg_idx_t REG_LENGTH_0  = 3'd4;

	// result slots: one match slot and one total slot per signature
	localparam int SLOTS  = 4;
	localparam int PEND_W = 2 * SLOTS;
	localparam int SEL_W  = 3;

	typedef logic [SEL_W-1:0] slot_sel_t;

	localparam logic KIND_MATCH = 1'b0;
	localparam logic KIND_TOTAL = 1'b1;

endpackage

@@ src/multi_signature_byte_scanner.sv @@
// Multi-signature byte scanner (uses msbs_pkg): history register, parallel
// signature compare, result slots drained one per cycle unless stalled.
//
// Usage:
//   Input channel (byte_valid/byte_stall) carries one image byte per beat,
//   with end_of_data marking the final byte of the image. Each beat is
//   compared against up to four signatures ending at that byte; matches
//   and, on the final byte, per-signature totals are captured together.
//   Output channel (result_valid/result_stall) delivers those results one
//   per beat, matches first by signature, then totals; last marks the final
//   result caused by a byte. A byte with no results produces no beat.
//   Latency: results appear the cycle after the byte is taken. Throughput:
//   one byte per cycle while each byte yields at most one result and
//   result_stall is low; with more, the next byte is taken in the cycle the
//   last of them leaves. A stall on the output holds the current result and
//   backs up into byte_stall. Configuration is written through cfg_we/
//   cfg_index/cfg_data; the user must write it only while the block is idle
//   (not enforced). Reset clears configuration, history, position, match
//   state and pending results; the final byte clears stream state only.
module multi_signature_byte_scanner #(
	parameter int NUM_SIGNATURES    = 4,
	parameter int MAX_PATTERN_BYTES = 8,
	parameter int OFFSET_BITS       = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  msbs_pkg::cfg_idx_t              cfg_index,
	input  logic [msbs_pkg::PAT_W-1:0]      cfg_data,
	// byte channel
	input  logic                            byte_valid,
	output logic                            byte_stall,
	input  logic [7:0]                      data_byte,
	input  logic                            end_of_data,
	// result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            kind,
	output logic [1:0]                      signature_index,
	output logic [msbs_pkg::VALUE_W-1:0]    value,
	output logic                            last
);

	localparam int HIST_W = (MAX_PATTERN_BYTES - 1) * 8;
	localparam int AGE_W  = $clog2(MAX_PATTERN_BYTES);
	localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
	localparam logic [msbs_pkg::VALUE_W-1:0] COUNT_MAX = {msbs_pkg::VALUE_W{1'b1}};

	// configuration
	logic [msbs_pkg::PAT_W-1:0] pattern_q [NUM_SIGNATURES];
	logic [msbs_pkg::LEN_W-1:0] length_q  [NUM_SIGNATURES];

	// stream state
	logic [HIST_W-1:0]             hist_q;
	logic [OFFSET_BITS-1:0]        pos_q;
	logic [OFFSET_BITS-1:0]        nas_q [NUM_SIGNATURES];
	logic [msbs_pkg::VALUE_W-1:0]  cnt_q [NUM_SIGNATURES];

	// result stage
	logic [msbs_pkg::PEND_W-1:0]   pend_s1;
	logic [OFFSET_BITS-1:0]        start_s1 [NUM_SIGNATURES];
	logic [msbs_pkg::VALUE_W-1:0]  total_s1 [NUM_SIGNATURES];

	// next-state logic
	logic [7:0]                    win [MAX_PATTERN_BYTES];
	logic [OFFSET_BITS-1:0]        after;
	logic [OFFSET_BITS-1:0]        start_c [NUM_SIGNATURES];
	logic [OFFSET_BITS-1:0]        nas_n [NUM_SIGNATURES];
	logic [msbs_pkg::VALUE_W-1:0]  cnt_n [NUM_SIGNATURES];
	logic [msbs_pkg::PEND_W-1:0]   pend_n;
	logic [HIST_W-1:0]             hist_n;

	logic in_acc, out_acc, single;

	always_comb begin
		logic [msbs_pkg::LEN_W-1:0] elen;
		logic [msbs_pkg::LEN_W-1:0] lm1;
		logic [msbs_pkg::LEN_W-1:0] age;
		logic                       hit;
		win[0] = data_byte;
		for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
			win[k] = hist_q[8*(k-1) +: 8];
		end
		after  = (pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;
		hist_n = HIST_W'({hist_q, data_byte});
		pend_n = '0;
		for (int s = 0; s < NUM_SIGNATURES; s++) begin
			elen = (length_q[s] > msbs_pkg::LEN_W'(MAX_PATTERN_BYTES)) ?
				msbs_pkg::LEN_W'(MAX_PATTERN_BYTES) : length_q[s];
			lm1 = elen - 1'b1;
			start_c[s] = pos_q - OFFSET_BITS'(lm1);
			hit = (elen != '0) && (pos_q >= OFFSET_BITS'(lm1)) &&
				(start_c[s] >= nas_q[s]);
			for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
				age = lm1 - msbs_pkg::LEN_W'(i);
				if (msbs_pkg::LEN_W'(i) < elen &&
					win[age[AGE_W-1:0]] != pattern_q[s][8*i +: 8]) begin
					hit = 1'b0;
				end
			end
			nas_n[s] = hit ? after : nas_q[s];
			cnt_n[s] = (hit && cnt_q[s] != COUNT_MAX) ? cnt_q[s] + 1'b1 : cnt_q[s];
			pend_n[s] = hit;
			pend_n[msbs_pkg::SLOTS + s] = end_of_data && (elen != '0) && (cnt_n[s] != '0);
		end
	end

	// output selection: lowest pending slot first
	always_comb begin
		msbs_pkg::slot_sel_t             sel;
		logic                            found;
		logic [OFFSET_BITS+31:0]         ext;
		logic [msbs_pkg::PEND_W-1:0]     rest;
		sel   = '0;
		found = 1'b0;
		for (int b = 0; b < msbs_pkg::PEND_W; b++) begin
			if (!found && pend_s1[b]) begin
				sel   = msbs_pkg::SEL_W'(b);
				found = 1'b1;
			end
		end
		rest            = pend_s1 & ~(msbs_pkg::PEND_W'(1) << sel);
		single          = found && (rest == '0);
		result_valid    = found;
		kind            = sel[2] ? msbs_pkg::KIND_TOTAL : msbs_pkg::KIND_MATCH;
		signature_index = sel[1:0];
		last            = single;
		value           = '0;
		ext             = '0;
		for (int s = 0; s < NUM_SIGNATURES; s++) begin
			if (sel[1:0] == 2'(s)) begin
				ext   = {32'd0, start_s1[s]};
				value = (kind == msbs_pkg::KIND_TOTAL) ? total_s1[s] : ext[31:0];
			end
		end
	end

	// take a new byte once the result register empties this cycle
	assign out_acc    = result_valid && !result_stall;
	assign byte_stall = !((pend_s1 == '0) || (single && !result_stall));
	assign in_acc     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SIGNATURES; s++) begin
				pattern_q[s] <= '0;
				length_q[s]  <= '0;
			end
		end else if (cfg_we) begin
			for (int s = 0; s < NUM_SIGNATURES; s++) begin
				if (cfg_index == msbs_pkg::REG_PATTERN_0 + msbs_pkg::CFG_IDX_W'(s)) begin
					pattern_q[s] <= cfg_data;
				end
				if (cfg_index == msbs_pkg::REG_LENGTH_0 + msbs_pkg::CFG_IDX_W'(s)) begin
					length_q[s] <= cfg_data[msbs_pkg::LEN_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			pos_q   <= '0;
			pend_s1 <= '0;
			for (int s = 0; s < NUM_SIGNATURES; s++) begin
				nas_q[s] <= '0;
				cnt_q[s] <= '0;
			end
		end else begin
			if (in_acc) begin
				pend_s1 <= pend_n;
				if (end_of_data) begin
					hist_q <= '0;
					pos_q  <= '0;
					for (int s = 0; s < NUM_SIGNATURES; s++) begin
						nas_q[s] <= '0;
						cnt_q[s] <= '0;
					end
				end else begin
					hist_q <= hist_n;
					pos_q  <= after;
					for (int s = 0; s < NUM_SIGNATURES; s++) begin
						nas_q[s] <= nas_n[s];
						cnt_q[s] <= cnt_n[s];
					end
				end
			end else if (out_acc) begin
				// drop the slot just delivered
				pend_s1 <= pend_s1 & (pend_s1 - 1'b1);
			end
		end
	end

	// result payload, loaded with each accepted byte
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int s = 0; s < NUM_SIGNATURES; s++) begin
				start_s1[s] <= start_c[s];
				total_s1[s] <= cnt_n[s];
			end
		end
	end

endmodule
